### rtl/core/gpio_prb_pkg.sv
// Shared types, codes and pin map of the GPIO port register block.
package gpio_prb_pkg;

    localparam int NUM_PORTS = 5;
    localparam int NUM_PINS  = 26;

    localparam logic [7:0] PUD_MASK = 8'h10;
    localparam logic [7:0] PORT_B_MASK = 8'hFF;
    localparam logic [7:0] PORT_C_MASK = 8'hC0;
    localparam logic [7:0] PORT_D_MASK = 8'hFF;
    localparam logic [7:0] PORT_E_MASK = 8'h44;
    localparam logic [7:0] PORT_F_MASK = 8'hF3;

    localparam logic [3:0] REG_CONTROL   = 4'd0;
    localparam logic [3:0] REG_DIR_FIRST = 4'd1;
    localparam logic [3:0] REG_DIR_LAST  = 4'd5;
    localparam logic [3:0] REG_LVL_FIRST = 4'd6;
    localparam logic [3:0] REG_LVL_LAST  = 4'd10;
    localparam logic [3:0] REG_PAD_FIRST = 4'd11;

    typedef enum logic [2:0] {
        CMD_WRITE_REG = 3'd0,
        CMD_READ_REG  = 3'd1,
        CMD_SET_DIR   = 3'd2,
        CMD_GET_DIR   = 3'd3,
        CMD_SET_LVL   = 3'd4,
        CMD_GET_LVL   = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_BAD_PIN = 2'd1,
        STATUS_BAD_REG = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        REGK_CTRL,
        REGK_DIR,
        REGK_LVL,
        REGK_PAD
    } reg_kind_t;

    typedef logic [2:0] port_idx_t;

    typedef struct packed {
        logic [2:0] command;
        logic [3:0] reg_sel;
        logic [4:0] pin_sel;
        logic [7:0] data;
        logic [7:0] pad_b;
        logic [7:0] pad_c;
        logic [7:0] pad_d;
        logic [7:0] pad_e;
        logic [7:0] pad_f;
    } in_word_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] read_data;
    } out_word_t;

    typedef struct packed {
        logic       valid;
        port_idx_t  port;
        logic [2:0] bit_pos;
    } pin_info_t;

    function automatic logic [7:0] port_mask(input port_idx_t port);
        logic [7:0] mask;
        unique case (port)
            3'd0:    mask = PORT_B_MASK;
            3'd1:    mask = PORT_C_MASK;
            3'd2:    mask = PORT_D_MASK;
            3'd3:    mask = PORT_E_MASK;
            3'd4:    mask = PORT_F_MASK;
            default: mask = 8'h00;
        endcase
        return mask;
    endfunction

    function automatic pin_info_t pin_lookup(input logic [4:0] pin);
        pin_info_t info;
        info.valid = 1'b1;
        if (pin < 5'd8) begin
            info.port    = 3'd0;
            info.bit_pos = pin[2:0];
        end else if (pin < 5'd10) begin
            info.port    = 3'd1;
            info.bit_pos = (pin == 5'd8) ? 3'd6 : 3'd7;
        end else if (pin < 5'd18) begin
            info.port    = 3'd2;
            info.bit_pos = 3'(pin - 5'd10);
        end else if (pin < 5'd20) begin
            info.port    = 3'd3;
            info.bit_pos = (pin == 5'd18) ? 3'd2 : 3'd6;
        end else if (pin < 5'd22) begin
            info.port    = 3'd4;
            info.bit_pos = (pin == 5'd20) ? 3'd0 : 3'd1;
        end else if (pin < 5'd26) begin
            info.port    = 3'd4;
            info.bit_pos = 3'(pin - 5'd18);
        end else begin
            info.valid   = 1'b0;
            info.port    = 3'd0;
            info.bit_pos = 3'd0;
        end
        return info;
    endfunction

endpackage

### rtl/core/gpio_prb_regfile.sv
// Port register file with command decode and masked read-modify-write.
module gpio_prb_regfile (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   exec_en,
    input  gpio_prb_pkg::in_word_t cmd_word,
    output gpio_prb_pkg::out_word_t result
);
    import gpio_prb_pkg::*;

    logic [7:0]                    ctrl_reg, ctrl_next;
    logic [NUM_PORTS-1:0][7:0]     dir_reg, dir_next;
    logic [NUM_PORTS-1:0][7:0]     lvl_reg, lvl_next;

    pin_info_t  pin_info;
    reg_kind_t  reg_kind;
    port_idx_t  reg_port;
    port_idx_t  port_idx;
    logic       is_reg_cmd;
    logic [7:0] mask;
    logic [7:0] dir_cur;
    logic [7:0] lvl_cur;
    logic [7:0] pad_cur;
    logic [7:0] target;
    logic [7:0] bit_mask;
    logic [7:0] target_new;

    always_comb begin
        pin_info = pin_lookup(cmd_word.pin_sel);

        if (cmd_word.reg_sel == REG_CONTROL) begin
            reg_kind = REGK_CTRL;
            reg_port = 3'd0;
        end else if (cmd_word.reg_sel <= REG_DIR_LAST) begin
            reg_kind = REGK_DIR;
            reg_port = 3'(cmd_word.reg_sel - REG_DIR_FIRST);
        end else if (cmd_word.reg_sel <= REG_LVL_LAST) begin
            reg_kind = REGK_LVL;
            reg_port = 3'(cmd_word.reg_sel - REG_LVL_FIRST);
        end else begin
            reg_kind = REGK_PAD;
            reg_port = 3'(cmd_word.reg_sel - REG_PAD_FIRST);
        end

        is_reg_cmd = (cmd_word.command == CMD_WRITE_REG)
                  || (cmd_word.command == CMD_READ_REG);
        port_idx   = is_reg_cmd ? reg_port : pin_info.port;

        mask    = port_mask(port_idx);
        dir_cur = dir_reg[port_idx];
        lvl_cur = lvl_reg[port_idx];

        unique case (reg_port)
            3'd0:    pad_cur = cmd_word.pad_b;
            3'd1:    pad_cur = cmd_word.pad_c;
            3'd2:    pad_cur = cmd_word.pad_d;
            3'd3:    pad_cur = cmd_word.pad_e;
            3'd4:    pad_cur = cmd_word.pad_f;
            default: pad_cur = 8'h00;
        endcase

        target     = ((cmd_word.command == CMD_SET_DIR)
                   || (cmd_word.command == CMD_GET_DIR)) ? dir_cur : lvl_cur;
        bit_mask   = 8'h01 << pin_info.bit_pos;
        target_new = ((target & ~bit_mask) | (cmd_word.data[0] ? bit_mask : 8'h00)) & mask;

        ctrl_next        = ctrl_reg;
        dir_next         = dir_reg;
        lvl_next         = lvl_reg;
        result.status    = STATUS_OK;
        result.read_data = 8'h00;

        unique case (cmd_word.command)
            CMD_WRITE_REG: begin
                unique case (reg_kind)
                    REGK_CTRL: ctrl_next = cmd_word.data & PUD_MASK;
                    REGK_DIR:  dir_next[port_idx] = cmd_word.data & mask;
                    REGK_LVL:  lvl_next[port_idx] = cmd_word.data & mask;
                    default:   result.status = STATUS_BAD_REG;
                endcase
            end
            CMD_READ_REG: begin
                unique case (reg_kind)
                    REGK_CTRL: result.read_data = ctrl_reg;
                    REGK_DIR:  result.read_data = dir_cur;
                    REGK_LVL:  result.read_data = lvl_cur;
                    default:   result.read_data = pad_cur;
                endcase
            end
            CMD_SET_DIR, CMD_SET_LVL: begin
                if (!pin_info.valid) begin
                    result.status = STATUS_BAD_PIN;
                end else if (cmd_word.command == CMD_SET_DIR) begin
                    dir_next[port_idx] = target_new;
                end else begin
                    lvl_next[port_idx] = target_new;
                end
            end
            CMD_GET_DIR, CMD_GET_LVL: begin
                if (!pin_info.valid) begin
                    result.status = STATUS_BAD_PIN;
                end else begin
                    result.read_data = {7'b0, target[pin_info.bit_pos]};
                end
            end
            default: result.status = STATUS_BAD_REG;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
            dir_reg  <= '0;
            lvl_reg  <= '0;
        end else if (exec_en) begin
            ctrl_reg <= ctrl_next;
            dir_reg  <= dir_next;
            lvl_reg  <= lvl_next;
        end
    end

    a_ctrl_only_pud: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl_reg & ~PUD_MASK) == 8'h00)
        else $error("Control register holds bits other than pull-up disable.");

    a_unmapped_pins_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        ((dir_reg[1] & ~PORT_C_MASK) == 8'h00) && ((lvl_reg[1] & ~PORT_C_MASK) == 8'h00)
        && ((dir_reg[3] & ~PORT_E_MASK) == 8'h00) && ((lvl_reg[3] & ~PORT_E_MASK) == 8'h00)
        && ((dir_reg[4] & ~PORT_F_MASK) == 8'h00) && ((lvl_reg[4] & ~PORT_F_MASK) == 8'h00))
        else $error("A port register holds a bit for a pin that does not exist.");

    a_error_keeps_state: assert property (@(posedge aclk) disable iff (!aresetn)
        exec_en && (result.status != STATUS_OK)
        |=> $stable(ctrl_reg) && $stable(dir_reg) && $stable(lvl_reg))
        else $error("A rejected command changed a register.");

    a_read_keeps_state: assert property (@(posedge aclk) disable iff (!aresetn)
        exec_en && ((cmd_word.command == CMD_READ_REG) || (cmd_word.command == CMD_GET_DIR)
                    || (cmd_word.command == CMD_GET_LVL))
        |=> $stable(ctrl_reg) && $stable(dir_reg) && $stable(lvl_reg))
        else $error("A read command changed a register.");

endmodule

### rtl/core/gpio_port_register_block_core.sv
// Top level of the GPIO port register block: input register, register file, result register.
//
//   Channel   Direction   Ports                      Word
//   s_        in          s_valid s_ready s_word     command, selects, data, pad levels
//   m_        out         m_valid m_ready m_word     status, read_data
//
// An accepted word is loaded into the input register; when it advances, the register file
// decode is loaded into the result register.
// A new word is accepted every cycle while the result side keeps taking words.
// When m_ready is low the result register holds and the input register fills,
// after which s_ready drops until the result is taken.
// Reset clears all port registers and both valid flags.
module gpio_port_register_block_core (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  gpio_prb_pkg::in_word_t  s_word,
    output logic                    m_valid,
    input  logic                    m_ready,
    output gpio_prb_pkg::out_word_t m_word
);
    import gpio_prb_pkg::*;

    logic      in_valid_reg, in_valid_next;
    in_word_t  in_word_reg;
    logic      out_valid_reg, out_valid_next;
    out_word_t out_word_reg;
    out_word_t exec_result;
    logic      advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_word  = out_word_reg;

    gpio_prb_regfile u_regfile (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .exec_en  (advance),
        .cmd_word (in_word_reg),
        .result   (exec_result)
    );

    always_comb begin
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end

        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= s_word;
        end
        if (advance) begin
            out_word_reg <= exec_result;
        end
    end

    a_stall_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_word_reg))
        else $error("A waiting input word was lost or overwritten.");

    a_stall_holds_result: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |=> out_valid_reg && $stable(out_word_reg))
        else $error("A waiting result word was lost or overwritten.");

    a_advance_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("An executed word produced no result.");

endmodule
